// ===== design/owvr_pkg.sv =====
// ----------------------------------------------------------------------------
// owvr_pkg
// Shared types and constants for the omni wheel velocity ramp PWM block.
// ----------------------------------------------------------------------------
package owvr_pkg;

  localparam int VALUE_WIDTH = 16;
  localparam int FRAC_BITS   = VALUE_WIDTH - 2;
  localparam int GAIN_FRAC   = 14;
  localparam int KIN_FRAC    = 16;

  // serial multiplier operand widths: magnitude by unsigned factor
  localparam int MUL_A_W   = 17;
  localparam int MUL_B_W   = 16;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = $clog2(MUL_B_W);

  localparam logic [15:0] KIN_COS = 16'd56756;
  localparam logic [14:0] ONE_MAG = 15'd16384;

  typedef enum logic [2:0] {
    R_TGAIN = 3'd0,
    R_RGAIN = 3'd1,
    R_SLEW  = 3'd2,
    R_DEAD  = 3'd3,
    R_STOP  = 3'd4,
    R_FWD   = 3'd5,
    R_REV   = 3'd6,
    R_SPAN  = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

endpackage

// ===== design/owvr_serial_mul.sv =====
// ----------------------------------------------------------------------------
// owvr_serial_mul
// Shift-add multiplier, one bit of the b operand per cycle.
// ----------------------------------------------------------------------------
module owvr_serial_mul import owvr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  mul_req_t           req,
  output logic               done,
  output logic [MUL_P_W-1:0] prod
);

  logic [MUL_A_W-1:0]   a_hold;
  logic [MUL_P_W-1:0]   acc;
  logic [MUL_CNT_W-1:0] cnt;
  logic                 busy;
  logic [MUL_A_W:0]     sum;

  assign sum  = {1'b0, acc[MUL_P_W-1:MUL_B_W]} + (acc[0] ? {1'b0, a_hold} : '0);
  assign prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == MUL_CNT_W'(MUL_B_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_hold <= req.a;
      acc    <= {{MUL_A_W{1'b0}}, req.b};
    end else if (busy) begin
      acc <= {sum, acc[MUL_B_W-1:1]};
    end
  end

endmodule

// ===== design/omni_wheel_velocity_ramp_pwm.sv =====
// ----------------------------------------------------------------------------
// omni_wheel_velocity_ramp_pwm
// Gain, slew ramp, three wheel omni kinematics and PWM count mapping.
// ----------------------------------------------------------------------------
// Sequence: each request takes seven passes of the shared 17 by 16 bit shift-add
// multiplier (three gain, one kinematics, three count), the S_KIN step for each
// wheel and the S_OUT step that registers the result.
// Intake: a request is not taken before the previous one is through; the next request is taken as soon
// as the previous result is registered, even while it still waits downstream.
// Reset: registers take their documented defaults, ramped velocities clear.
module omni_wheel_velocity_ramp_pwm import owvr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] cmd_x,
  input  logic [15:0] cmd_y,
  input  logic [15:0] cmd_omega,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] front_count,
  output logic [15:0] back_left_count,
  output logic [15:0] back_right_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [10:0] {
    S_IDLE      = 11'b00000000001,
    S_GAIN_GO   = 11'b00000000010,
    S_GAIN_WAIT = 11'b00000000100,
    S_RAMP      = 11'b00000001000,
    S_KMUL_GO   = 11'b00000010000,
    S_KMUL_WAIT = 11'b00000100000,
    S_KIN       = 11'b00001000000,
    S_CMUL_GO   = 11'b00010000000,
    S_CMUL_WAIT = 11'b00100000000,
    S_CNT       = 11'b01000000000,
    S_OUT       = 11'b10000000000
  } state_t;

  state_t state, state_next;

  logic [14:0] translation_gain, rotation_gain, slew_step;
  logic [10:0] dead_zone;
  logic [15:0] stop_count, forward_start_count, reverse_start_count, count_span;

  logic signed [15:0] cmd [3];
  logic signed [15:0] ramp [3];
  logic signed [15:0] speed [3];
  logic [15:0]        count [3];
  logic [1:0]         idx;
  logic signed [35:0] cx;

  mul_req_t           mreq;
  logic               mdone;
  logic [MUL_P_W-1:0] mprod;

  owvr_serial_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mreq),
    .done (mdone),
    .prod (mprod)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      translation_gain    <= 15'd16384;
      rotation_gain       <= 15'd16384;
      slew_step           <= 15'd164;
      dead_zone           <= 11'd2;
      stop_count          <= 16'd1500;
      forward_start_count <= 16'd1520;
      reverse_start_count <= 16'd1480;
      count_span          <= 16'd400;
    end else if (cfg_valid) begin
      case (reg_index_t'(cfg_index))
        R_TGAIN: translation_gain    <= cfg_data[14:0];
        R_RGAIN: rotation_gain       <= cfg_data[14:0];
        R_SLEW:  slew_step           <= cfg_data[14:0];
        R_DEAD:  dead_zone           <= cfg_data[10:0];
        R_STOP:  stop_count          <= cfg_data;
        R_FWD:   forward_start_count <= cfg_data;
        R_REV:   reverse_start_count <= cfg_data;
        R_SPAN:  count_span          <= cfg_data;
        default: ;
      endcase
    end
  end

  // operand magnitudes
  logic signed [15:0] cmd_sel, speed_sel;
  logic [16:0]        cmd_mag;
  logic [14:0]        vx_mag, speed_mag;

  assign cmd_sel   = cmd[idx];
  assign speed_sel = speed[idx];
  assign cmd_mag   = cmd_sel[15] ? 17'(-{1'b1, cmd_sel}) : {1'b0, cmd_sel};
  assign vx_mag    = ramp[0][15] ? 15'(-ramp[0]) : ramp[0][14:0];
  assign speed_mag = speed_sel[15] ? 15'(-speed_sel) : speed_sel[14:0];

  always_comb begin
    mreq = '0;
    case (state)
      S_GAIN_GO: begin
        mreq.start = 1'b1;
        mreq.a     = cmd_mag;
        mreq.b     = {1'b0, (idx == 2'd2) ? rotation_gain : translation_gain};
      end
      S_KMUL_GO: begin
        mreq.start = 1'b1;
        mreq.a     = {2'b0, vx_mag};
        mreq.b     = KIN_COS;
      end
      S_CMUL_GO: begin
        mreq.start = 1'b1;
        mreq.a     = {2'b0, speed_mag};
        mreq.b     = count_span;
      end
      default: ;
    endcase
  end

  // ramp step
  logic [18:0]        tgt_raw;
  logic [14:0]        tgt_mag;
  logic signed [17:0] tgt, diff, diff_clip, slew_s;
  logic signed [15:0] ramp_new;

  always_comb begin
    tgt_raw   = mprod[32:GAIN_FRAC];
    tgt_mag   = (tgt_raw > {4'b0, ONE_MAG}) ? ONE_MAG : tgt_raw[14:0];
    tgt       = cmd_sel[15] ? -$signed({3'b0, tgt_mag}) : $signed({3'b0, tgt_mag});
    diff      = tgt - 18'(ramp[idx]);
    slew_s    = $signed({3'b0, slew_step});
    if (diff > slew_s)       diff_clip = slew_s;
    else if (diff < -slew_s) diff_clip = -slew_s;
    else                     diff_clip = diff;
    ramp_new  = 16'(18'(ramp[idx]) + diff_clip);
  end

  // wheel sum for the wheel at idx
  logic signed [35:0] vy36, om36, wsum;
  logic [35:0]        wabs;
  logic [19:0]        wq;
  logic [14:0]        wmag;
  logic signed [15:0] wspeed;

  always_comb begin
    vy36 = 36'(ramp[1]);
    om36 = 36'(ramp[2]);
    case (idx)
      2'd0:    wsum = (vy36 + om36) <<< KIN_FRAC;
      2'd1:    wsum = -cx - (vy36 <<< 15) + (om36 <<< KIN_FRAC);
      default: wsum = cx - (vy36 <<< 15) + (om36 <<< KIN_FRAC);
    endcase
    wabs   = wsum[35] ? 36'(-wsum) : 36'(wsum);
    wq     = wabs[35:KIN_FRAC];
    wmag   = (wq > {5'b0, ONE_MAG}) ? ONE_MAG : wq[14:0];
    wspeed = wsum[35] ? -$signed({1'b0, wmag}) : $signed({1'b0, wmag});
  end

  // count mapping
  logic [17:0]        q;
  logic signed [19:0] cval;
  logic [15:0]        cnt_val;

  always_comb begin
    q = mprod[31:FRAC_BITS];
    if (!speed_sel[15] && speed_sel != 16'sd0)
      cval = $signed({4'b0, forward_start_count}) + $signed({2'b0, q});
    else
      cval = $signed({4'b0, reverse_start_count}) - $signed({2'b0, q});
    if ({4'b0, speed_mag} < {8'b0, dead_zone}) cnt_val = stop_count;
    else if (cval < 20'sd0)                    cnt_val = 16'd0;
    else if (cval > 20'sd65535)                cnt_val = 16'hFFFF;
    else                                       cnt_val = cval[15:0];
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (in_valid) state_next = S_GAIN_GO;
      S_GAIN_GO:   state_next = S_GAIN_WAIT;
      S_GAIN_WAIT: if (mdone) state_next = S_RAMP;
      S_RAMP:      state_next = (idx == 2'd2) ? S_KMUL_GO : S_GAIN_GO;
      S_KMUL_GO:   state_next = S_KMUL_WAIT;
      S_KMUL_WAIT: if (mdone) state_next = S_KIN;
      S_KIN:       if (idx == 2'd2) state_next = S_CMUL_GO;
      S_CMUL_GO:   state_next = S_CMUL_WAIT;
      S_CMUL_WAIT: if (mdone) state_next = S_CNT;
      S_CNT:       state_next = (idx == 2'd2) ? S_OUT : S_CMUL_GO;
      S_OUT:       if (!out_valid || !out_stall) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < 3; i++) ramp[i] <= '0;
    end else begin
      state <= state_next;
      if (state == S_OUT && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall)                 out_valid <= 1'b0;
      case (state)
        S_IDLE: idx <= '0;
        S_RAMP: begin
          ramp[idx] <= ramp_new;
          idx       <= (idx == 2'd2) ? 2'd0 : idx + 2'd1;
        end
        S_KIN: idx <= (idx == 2'd2) ? 2'd0 : idx + 2'd1;
        S_CNT: idx <= (idx == 2'd2) ? 2'd0 : idx + 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cmd[0] <= cmd_x;
      cmd[1] <= cmd_y;
      cmd[2] <= cmd_omega;
    end
    if (state == S_KMUL_WAIT && mdone)
      cx <= ramp[0][15] ? -$signed({3'b0, mprod}) : $signed({3'b0, mprod});
    if (state == S_KIN) speed[idx] <= wspeed;
    if (state == S_CNT) count[idx] <= cnt_val;
    if (state == S_OUT && (!out_valid || !out_stall)) begin
      front_count      <= count[0];
      back_left_count  <= count[1];
      back_right_count <= count[2];
    end
  end

endmodule
